// ===== src/assert_macros.svh =====
// Assertion helpers used by the filter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop is a full property expression, sampled on the rising clock edge
`define BLF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expr must never be true
`define BLF_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BLF_ASSERT(lbl, clk, rst, prop, msg)
`define BLF_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== src/blf_pkg.sv =====
package blf_pkg;

   localparam int MAX_WIDTH_DEF = 2048;

   localparam int PIX_W     = 8;
   localparam int COL_OUT_W = 11;
   localparam int ROW_W     = 12;
   localparam int DIM_W     = 12;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int MIN_DIM      = 3;

   // 3x3 sum of 8-bit pixels, max 2295
   localparam int SUM_W = 12;
   // floor(s/9) == (s * 7282) >> 16 for every s up to 2295
   localparam int MEAN_RECIP = 7282;
   localparam int RECIP_W    = 13;
   localparam int MEAN_SHIFT = 16;
   localparam int PROD_W     = 24;

   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int RSP_DATA_W = 40;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } blf_reg_type;

   typedef struct packed {
      logic [COL_OUT_W-1:0] out_col;
      logic [ROW_W-1:0]     out_row;
      logic                 frame_last;
   } blf_tag_type;

   // pixel stage control handed to the window pipeline
   typedef struct packed {
      logic        valid;
      logic        produce;
      blf_tag_type tag;
   } blf_stage_type;

   typedef struct packed {
      logic [PIX_W-1:0] mean_value;
      logic [PIX_W-1:0] edge_value;
      blf_tag_type      tag;
   } blf_result_type;

endpackage

// ===== src/blf_line_mem.sv =====
module blf_line_mem import blf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output logic [2*PIX_W-1:0]           rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [2*PIX_W-1:0]           wr_data
);

   // each entry: {upper line pixel, middle line pixel} for one column
   logic [2*PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/blf_window.sv =====
module blf_window import blf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  blf_stage_type    s1,
   input  logic [PIX_W-1:0] up_px,
   input  logic [PIX_W-1:0] mid_px,
   input  logic [PIX_W-1:0] low_px,
   output logic             res_valid,
   output blf_result_type   res
);

   localparam int LAP_W = 12;

   // [row 0 top .. 2 bottom][col 0 left .. 2 right]
   logic [PIX_W-1:0] win_ff [3][3];
   logic             v2_ff, v3_ff, v4_ff;
   blf_tag_type      tag2_ff, tag3_ff, tag4_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [PIX_W-1:0] edge3_ff, edge4_ff;
   logic [PROD_W-1:0] prod_ff;

   logic [SUM_W-1:0]         sum_in;
   logic signed [LAP_W-1:0]  lap;
   logic [LAP_W-1:0]         lap_mag;
   logic [PIX_W-1:0]         edge_in;
   logic [SUM_W+RECIP_W-1:0] prod_full;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum_in = sum_in + SUM_W'(win_ff[i][j]);
         end
      end
      lap = $signed({4'b0, win_ff[0][1]}) + $signed({4'b0, win_ff[2][1]})
          + $signed({4'b0, win_ff[1][0]}) + $signed({4'b0, win_ff[1][2]})
          - $signed({2'b0, win_ff[1][1], 2'b0});
      lap_mag = lap[LAP_W-1] ? LAP_W'(-lap) : LAP_W'(lap);
      // doubling saturates once the magnitude passes 127
      if (lap_mag > LAP_W'(127)) begin
         edge_in = '1;
      end else begin
         edge_in = {lap_mag[PIX_W-2:0], 1'b0};
      end
      prod_full = sum_ff * RECIP_W'(MEAN_RECIP);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s1.valid) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= up_px;
            win_ff[1][2] <= mid_px;
            win_ff[2][2] <= low_px;
         end
         tag2_ff  <= s1.tag;
         sum_ff   <= sum_in;
         edge3_ff <= edge_in;
         tag3_ff  <= tag2_ff;
         prod_ff  <= prod_full[PROD_W-1:0];
         edge4_ff <= edge3_ff;
         tag4_ff  <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= s1.valid && s1.produce;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign res_valid      = v4_ff;
   assign res.mean_value = prod_ff[MEAN_SHIFT +: PIX_W];
   assign res.edge_value = edge4_ff;
   assign res.tag        = tag4_ff;

endmodule

// ===== src/blf_out_skid.sv =====
module blf_out_skid import blf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  blf_result_type in_res,
   output logic           adv,
   output logic           out_valid,
   output blf_result_type out_res,
   input  logic           out_ready
);

   logic           out_valid_ff, skid_valid_ff;
   blf_result_type out_res_ff, skid_res_ff;
   logic           take, push;

   assign take = out_valid_ff && out_ready;
   // the pipeline moves only while the skid slot is free
   assign adv  = !skid_valid_ff;
   assign push = adv && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_res_ff    <= skid_res_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_res_ff   <= in_res;
            out_valid_ff <= 1'b1;
         end else begin
            skid_res_ff   <= in_res;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

endmodule

// ===== src/box_and_laplacian_3x3_filter_core.sv =====
// 3x3 box mean and Laplacian edge filter over a raster stream of 8-bit pixels.
// One pixel is taken per clock while the skid slot is free, and one result (mean,
// doubled absolute 4-neighbour Laplacian saturated to 255, centre column/row, tlast on
// the frame's last interior pixel) comes out, registered, for every interior pixel
// once the pixel that completes its window is taken. The rate is set by the line
// store: one dual-port memory of MAX_WIDTH entries holding the two previous rows, read
// and written once per pixel. A result held by rsp_tready parks in a one-entry skid
// slot, and req_tready drops only while that slot is full. Border pixels produce none.
// Width and height are written over the csr port at byte addresses 0 and 4 while the
// stream is idle; any write restarts the frame at pixel (0,0). No clearing pass follows
// reset: rows 0 and 1 of every frame fill the line store before it is read.
`include "assert_macros.svh"

module box_and_laplacian_3x3_filter_core import blf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] mean_value, [15:8] edge_value, [26:16] out_col, [38:27] out_row, [39] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // frame_last
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int EW        = ((CW > DIM_W) ? CW : DIM_W) + 1;
   localparam int WIDTH_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [CW-1:0]    col_count_ff;
   logic [ROW_W-1:0] row_count_ff;

   blf_stage_type    s1_ff;
   logic [PIX_W-1:0] s1_px_ff;
   logic [CW-1:0]    s1_col_ff;

   logic             csr_wr;
   blf_reg_type      csr_idx;
   logic [DIM_W-1:0] wdata;
   logic [DIM_W-1:0] width_in, height_in;

   logic             accept, pipe_adv;
   logic [EW-1:0]    col_ext, col_inc, col_m1;
   logic             col_wrap;
   logic [CW-1:0]    col_count_in;
   logic [ROW_W-1:0] row_count_in;
   blf_stage_type    s1_in;

   logic [CW-1:0]        rd_addr;
   logic [2*PIX_W-1:0]   rd_data;
   logic                 wr_en;
   logic                 res_valid;
   blf_result_type       res, out_res;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = blf_reg_type'(csr_paddr[2]);
   assign wdata      = csr_pwdata[DIM_W-1:0];

   always_comb begin
      if (wdata < DIM_W'(MIN_DIM)) begin
         width_in = DIM_W'(MIN_DIM);
      end else if (32'(wdata) > 32'(MAX_WIDTH)) begin
         width_in = DIM_W'(MAX_WIDTH);
      end else begin
         width_in = wdata;
      end
      height_in = (wdata < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) : wdata;
      if (csr_idx == REG_IMAGE_WIDTH) begin
         csr_prdata = CSR_DW'(width_ff);
      end else begin
         csr_prdata = CSR_DW'(height_ff);
      end
   end

   // raster position of the incoming pixel
   assign accept   = req_tvalid && req_tready;
   assign col_ext  = EW'(col_count_ff);
   assign col_inc  = col_ext + EW'(1);
   assign col_m1   = col_ext - EW'(1);
   assign col_wrap = col_inc >= EW'(width_ff);

   always_comb begin
      col_count_in = col_wrap ? '0 : col_inc[CW-1:0];
      row_count_in = row_count_ff;
      if (col_wrap) begin
         if ((ROW_W+1)'(row_count_ff) + (ROW_W+1)'(1) >= (ROW_W+1)'(height_ff)) begin
            row_count_in = '0;
         end else begin
            row_count_in = row_count_ff + ROW_W'(1);
         end
      end
      s1_in.valid          = accept;
      s1_in.produce        = (row_count_ff >= ROW_W'(2)) && (col_ext >= EW'(2));
      s1_in.tag.out_col    = col_m1[COL_OUT_W-1:0];
      s1_in.tag.out_row    = row_count_ff - ROW_W'(1);
      s1_in.tag.frame_last = (row_count_ff == height_ff - DIM_W'(1))
                          && (col_ext == EW'(width_ff) - EW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_W'(WIDTH_RST);
         height_ff    <= DIM_W'(HEIGHT_RESET);
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (csr_wr) begin
         if (csr_idx == REG_IMAGE_WIDTH) begin
            width_ff <= width_in;
         end else begin
            height_ff <= height_in;
         end
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // pixel stage: line store read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (pipe_adv) begin
         s1_ff.valid <= s1_in.valid;
      end
      if (pipe_adv && accept) begin
         s1_ff.produce <= s1_in.produce;
         s1_ff.tag     <= s1_in.tag;
         s1_px_ff      <= req_tdata;
         s1_col_ff     <= col_count_ff;
      end
   end

   assign req_tready = pipe_adv;

   // a stalled pixel stage keeps re-reading its own column
   assign rd_addr = pipe_adv ? col_count_ff : s1_col_ff;
   assign wr_en   = pipe_adv && s1_ff.valid;

   blf_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data ({rd_data[PIX_W-1:0], s1_px_ff})
   );

   blf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_adv),
      .s1        (s1_ff),
      .up_px     (rd_data[2*PIX_W-1:PIX_W]),
      .mid_px    (rd_data[PIX_W-1:0]),
      .low_px    (s1_px_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   blf_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .adv       (pipe_adv),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, out_res.tag.out_row, out_res.tag.out_col,
                       out_res.edge_value, out_res.mean_value};
   assign rsp_tlast = out_res.tag.frame_last;

   `BLF_ASSERT(a_col_in_range, clock, reset, EW'(col_count_ff) < EW'(width_ff), "column counter reached image width")
   `BLF_ASSERT(a_stall_holds_output, clock, reset, !pipe_adv |-> rsp_tvalid, "pipeline stalled with no result waiting")
   `BLF_ASSERT_NEVER(a_store_collision, clock, reset, wr_en && accept && (rd_addr == s1_col_ff), "line store read and write hit the same column")

endmodule

// ===== tb/box_and_laplacian_3x3_filter_core_test.sv =====
`timescale 1ns / 1ps

module box_and_laplacian_3x3_filter_core_test;
   import blf_pkg::*;

   typedef enum int {
      PIX_UNIFORM,
      PIX_EXTREME,
      PIX_FLAT
   } pixel_mix_type;

   // pixels left for the random frames once the directed tests are done
   localparam int RANDOM_ITEMS = 470;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;   // [7:0] pixel
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [7:0] mean_value, [15:8] edge_value, [26:16] out_col, [38:27] out_row, [39] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;   // frame_last
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_AW-1:0]     csr_paddr;
   logic [CSR_DW-1:0]     csr_pwdata;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   // shadow of the filter: line stores, window, raster position and frame size
   logic [PIX_W-1:0] upper_row [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] middle_row [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] win [3][3];
   int               col_pos;
   int               row_pos;
   int               cfg_width;
   int               cfg_height;

   blf_result_type   pending_results[$];
   int               mismatch_count = 0;
   int               random_sent = 0;
   bit               no_gaps = 1'b0;

   box_and_laplacian_3x3_filter_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void filter_pixel(logic [PIX_W-1:0] px);
      int             ci;
      int             i;
      int             j;
      int             sum;
      int             lap;
      blf_result_type res;
      ci = (col_pos < MAX_WIDTH_DEF) ? col_pos : 0;
      for (i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_row[ci];
      win[1][2] = middle_row[ci];
      win[2][2] = px;
      upper_row[ci] = middle_row[ci];
      middle_row[ci] = px;
      if (row_pos >= 2 && col_pos >= 2) begin
         sum = 0;
         for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
               sum += win[i][j];
         lap = 2 * (int'(win[0][1]) + int'(win[2][1]) + int'(win[1][0]) + int'(win[1][2])
                    - 4 * int'(win[1][1]));
         if (lap < 0) lap = -lap;
         if (lap > 255) lap = 255;
         res.mean_value     = PIX_W'(sum / 9);
         res.edge_value     = PIX_W'(lap);
         res.tag.out_col    = COL_OUT_W'(col_pos - 1);
         res.tag.out_row    = ROW_W'(row_pos - 1);
         res.tag.frame_last = (row_pos == cfg_height - 1) && (col_pos == cfg_width - 1);
         pending_results.push_back(res);
      end
      col_pos++;
      if (col_pos >= cfg_width) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= cfg_height) row_pos = 0;
      end
   endfunction

   function automatic void compare_field(string field, int expected_v, int actual_v);
      if (expected_v != actual_v) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, expected_v, actual_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      blf_result_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: unexpected result transfer, expected none, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               exp_r = pending_results.pop_front();
               compare_field("mean_value", exp_r.mean_value, rsp_tdata[7:0]);
               compare_field("edge_value", exp_r.edge_value, rsp_tdata[15:8]);
               compare_field("out_col", exp_r.tag.out_col, rsp_tdata[26:16]);
               compare_field("out_row", exp_r.tag.out_row, rsp_tdata[38:27]);
               compare_field("pad bit", 0, rsp_tdata[39]);
               compare_field("frame_last", exp_r.tag.frame_last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) filter_pixel(req_tdata);
      end
   end

   // result side backpressure
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (!no_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] px);
      if (!no_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_pixels(input int count, input pixel_mix_type mix);
      int n;
      for (n = 0; n < count; n++) begin
         case (mix)
            PIX_EXTREME: send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0);
            PIX_FLAT:    send_pixel(PIX_W'(120 + $urandom_range(0, 15)));
            default:     send_pixel(PIX_W'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // whole 3x3 frame: one ring value around one centre value
   task automatic send_grid(input logic [PIX_W-1:0] ring, input logic [PIX_W-1:0] centre);
      int k;
      for (k = 0; k < 9; k++) send_pixel((k == 4) ? centre : ring);
   endtask

   // border pixels produce nothing, so give the pipe time to empty after the queue does
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_dimension(input blf_reg_type which, input logic [CSR_DW-1:0] value);
      int dim;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      dim = value[DIM_W-1:0];
      if (dim < MIN_DIM) dim = MIN_DIM;
      if (which == REG_IMAGE_WIDTH) cfg_width = (dim > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : dim;
      else cfg_height = dim;
      col_pos = 0;
      row_pos = 0;
   endtask

   // read a size register back and hold it against the shadow
   task automatic check_dimension(input blf_reg_type which);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {which, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (which == REG_IMAGE_WIDTH) compare_field("image_width", cfg_width, csr_prdata);
      else compare_field("image_height", cfg_height, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // reset frame size: two full rows of 640 and into the third
   task automatic test_reset_dimensions();
      send_pixels(2 * WIDTH_RESET + 20, PIX_UNIFORM);
      settle();
   endtask

   // smallest frame, one result each, value extremes and saturation both ways
   task automatic test_corner_frames();
      write_dimension(REG_IMAGE_WIDTH, 32'd0);
      write_dimension(REG_IMAGE_HEIGHT, 32'd1);
      send_grid(8'd255, 8'd255);
      send_grid(8'd255, 8'd0);
      send_grid(8'd0, 8'd255);
      send_grid(8'd1, 8'd2);
      settle();
   endtask

   // writes in the middle of a frame restart it at pixel (0,0)
   task automatic test_frame_restart();
      write_dimension(REG_IMAGE_WIDTH, 32'hFFFF_F005);
      write_dimension(REG_IMAGE_HEIGHT, 32'd2);
      send_pixels(8, PIX_UNIFORM);
      settle();
      write_dimension(REG_IMAGE_HEIGHT, 32'd4);
      send_pixels(2 * 5 * 4, PIX_UNIFORM);
      send_pixels(7, PIX_EXTREME);
      settle();
      write_dimension(REG_IMAGE_WIDTH, 32'd6);
      send_pixels(6 * 4, PIX_EXTREME);
      settle();
   endtask

   // width above the maximum is taken as the maximum
   task automatic test_widest_rows();
      write_dimension(REG_IMAGE_WIDTH, 32'h0000_0FFF);
      check_dimension(REG_IMAGE_WIDTH);
      write_dimension(REG_IMAGE_WIDTH, 32'h0000_0801);
      check_dimension(REG_IMAGE_WIDTH);
   endtask

   // tallest frame: only the low twelve bits of the write count
   task automatic test_tallest_frame();
      write_dimension(REG_IMAGE_WIDTH, 32'd3);
      write_dimension(REG_IMAGE_HEIGHT, 32'hFFFF_FFFF);
      check_dimension(REG_IMAGE_HEIGHT);
      send_pixels(3 * 5, PIX_UNIFORM);
      settle();
   endtask

   task automatic test_random_frames();
      int            w;
      int            h;
      int            pick;
      int            frame_px;
      int            count;
      pixel_mix_type mix;
      while (random_sent < RANDOM_ITEMS) begin
         no_gaps = (random_sent > RANDOM_ITEMS - 120) || ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 2);
         else if ($urandom_range(0, 7) == 0) w = $urandom_range(41, 80);
         else w = $urandom_range(3, 20);
         if ($urandom_range(0, 7) == 0) h = $urandom_range(0, 2);
         else h = (w > 40) ? $urandom_range(3, 4) : $urandom_range(3, 8);
         pick = (random_sent == 0) ? 0 : $urandom_range(0, 3);
         if (pick != 2) write_dimension(REG_IMAGE_WIDTH, ($urandom() & 32'hFFFF_F000) | w);
         if (pick != 1) write_dimension(REG_IMAGE_HEIGHT, ($urandom() & 32'hFFFF_F000) | h);
         frame_px = cfg_width * cfg_height;
         count = frame_px * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, frame_px - 1);
         if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
         pick = $urandom_range(0, 5);
         mix = (pick < 4) ? PIX_UNIFORM : ((pick == 4) ? PIX_EXTREME : PIX_FLAT);
         send_pixels(count, mix);
         random_sent += count;
         settle();
      end
   endtask

   initial begin
      int k;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (k = 0; k < MAX_WIDTH_DEF; k++) begin
         upper_row[k]  = '0;
         middle_row[k] = '0;
      end
      for (k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
      col_pos    = 0;
      row_pos    = 0;
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_dimensions();
      test_corner_frames();
      test_frame_restart();
      test_widest_rows();
      test_tallest_frame();
      test_random_frames();

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
